// File: hw/rtl/gaf_pkg.sv
// gaf_pkg: shared widths, codes, control structs and the 40-bit saturation
// helper for the gyro and accelerometer angle fusion block
// no dependencies
package gaf_pkg;

  localparam int IN_W      = 16;
  localparam int ST_W      = 40;
  localparam int OP_W      = ST_W + 1;
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 16;
  localparam int SPLIT     = 20;
  localparam int MUL_A_W   = SPLIT + 1;
  localparam int MUL_B_W   = GAIN_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_IN_W  = 48;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = 48'sh007F_FFFF_FFFF;
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = 48'shFF80_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROLL_RATE_GAIN     = 3'd0,
    CFG_PITCH_RATE_GAIN    = 3'd1,
    CFG_ROLL_CORRECT_GAIN  = 3'd2,
    CFG_PITCH_CORRECT_GAIN = 3'd3,
    CFG_ROLL_BIAS_GAIN     = 3'd4,
    CFG_PITCH_BIAS_GAIN    = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_RG_LO,
    ST_RG_HI,
    ST_RG_FIN,
    ST_EST,
    ST_ERR,
    ST_CG_LO,
    ST_CG_HI,
    ST_CG_FIN,
    ST_BG_LO,
    ST_BG_HI,
    ST_BG_FIN,
    ST_BIAS,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_RATE,
    ALU_EST,
    ALU_ERR,
    ALU_CORR,
    ALU_BIAS
  } alu_op_t;

  typedef enum logic [1:0] {
    GSEL_RATE,
    GSEL_CORR,
    GSEL_BIAS
  } gsel_t;

  typedef struct packed {
    logic ld_lo;
    logic ld_hi;
    logic fin;
  } mul_ctrl_t;

  typedef struct packed {
    logic      in_ready;
    logic      axis;
    alu_op_t   alu_op;
    gsel_t     gsel;
    mul_ctrl_t mul;
    logic      out_load;
  } ctrl_t;

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SAT_IN_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[ST_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[ST_W-1:0];
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/gaf_mul.sv
// gaf_mul: shared gain multiplier, a 40-bit value times a 24-bit gain in two
// 20-bit halves, then floor shift by the gain fraction and saturation
// depends on gaf_pkg
module gaf_mul (
  input  logic                              clk,
  input  gaf_pkg::mul_ctrl_t                ctrl,
  input  logic signed [gaf_pkg::ST_W-1:0]   x,
  input  logic        [gaf_pkg::GAIN_W-1:0] g,
  output logic signed [gaf_pkg::ST_W-1:0]   sc
);

  logic signed [gaf_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [gaf_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [gaf_pkg::PROD_W-1:0]   prod;
  logic signed [gaf_pkg::PROD_W-1:0]   p_r;
  logic        [gaf_pkg::SPLIT+gaf_pkg::GAIN_W-1:0] acc_r;
  logic signed [gaf_pkg::PROD_W+gaf_pkg::SPLIT-1:0] full;
  logic signed [gaf_pkg::ST_W-1:0]     sc_nxt;
  logic signed [gaf_pkg::ST_W-1:0]     sc_r;

  // low half unsigned, high half signed
  assign mul_a = ctrl.ld_lo ? $signed({1'b0, x[gaf_pkg::SPLIT-1:0]})
                            : $signed({x[gaf_pkg::ST_W-1], x[gaf_pkg::ST_W-1:gaf_pkg::SPLIT]});
  assign mul_b = $signed({1'b0, g});
  assign prod  = mul_a * mul_b;

  assign full = $signed({p_r, {gaf_pkg::SPLIT{1'b0}}})
              + $signed({{(gaf_pkg::PROD_W-gaf_pkg::GAIN_W){1'b0}}, acc_r});
  assign sc_nxt = gaf_pkg::sat_st(
      $signed(full[gaf_pkg::SAT_IN_W+gaf_pkg::GAIN_FRAC-1:gaf_pkg::GAIN_FRAC]));

  always_ff @(posedge clk) begin
    if (ctrl.ld_lo || ctrl.ld_hi) begin
      p_r <= prod;
    end
    if (ctrl.ld_hi) begin
      acc_r <= p_r[gaf_pkg::SPLIT+gaf_pkg::GAIN_W-1:0];
    end
    if (ctrl.fin) begin
      sc_r <= sc_nxt;
    end
  end

  assign sc = sc_r;

endmodule

// File: hw/rtl/gaf_seq.sv
// gaf_seq: sequencer that steps both axes through the shared adder and
// multiplier and hands the result to the output register
// depends on gaf_pkg
module gaf_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_busy,
  output gaf_pkg::ctrl_t ctrl
);

  gaf_pkg::state_t state_r, state_nxt;
  logic            axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gaf_pkg::ST_IDLE;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      gaf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = gaf_pkg::ST_RATE;
          axis_nxt  = 1'b0;
        end
      end
      gaf_pkg::ST_RATE:   state_nxt = gaf_pkg::ST_RG_LO;
      gaf_pkg::ST_RG_LO:  state_nxt = gaf_pkg::ST_RG_HI;
      gaf_pkg::ST_RG_HI:  state_nxt = gaf_pkg::ST_RG_FIN;
      gaf_pkg::ST_RG_FIN: state_nxt = gaf_pkg::ST_EST;
      gaf_pkg::ST_EST:    state_nxt = gaf_pkg::ST_ERR;
      gaf_pkg::ST_ERR:    state_nxt = gaf_pkg::ST_CG_LO;
      gaf_pkg::ST_CG_LO:  state_nxt = gaf_pkg::ST_CG_HI;
      gaf_pkg::ST_CG_HI:  state_nxt = gaf_pkg::ST_CG_FIN;
      gaf_pkg::ST_CG_FIN: state_nxt = gaf_pkg::ST_BG_LO;
      gaf_pkg::ST_BG_LO:  state_nxt = gaf_pkg::ST_BG_HI;
      gaf_pkg::ST_BG_HI:  state_nxt = gaf_pkg::ST_BG_FIN;
      gaf_pkg::ST_BG_FIN: state_nxt = gaf_pkg::ST_BIAS;
      gaf_pkg::ST_BIAS: begin
        if (axis_r) begin
          state_nxt = gaf_pkg::ST_OUT;
        end else begin
          state_nxt = gaf_pkg::ST_RATE;
          axis_nxt  = 1'b1;
        end
      end
      gaf_pkg::ST_OUT: begin
        if (!out_busy) begin
          state_nxt = gaf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.axis     = axis_r;
    ctrl.alu_op   = gaf_pkg::ALU_NONE;
    ctrl.gsel     = gaf_pkg::GSEL_RATE;
    case (state_r)
      gaf_pkg::ST_IDLE:   ctrl.in_ready = 1'b1;
      gaf_pkg::ST_RATE:   ctrl.alu_op = gaf_pkg::ALU_RATE;
      gaf_pkg::ST_RG_LO:  ctrl.mul.ld_lo = 1'b1;
      gaf_pkg::ST_RG_HI:  ctrl.mul.ld_hi = 1'b1;
      gaf_pkg::ST_RG_FIN: ctrl.mul.fin = 1'b1;
      gaf_pkg::ST_EST:    ctrl.alu_op = gaf_pkg::ALU_EST;
      gaf_pkg::ST_ERR:    ctrl.alu_op = gaf_pkg::ALU_ERR;
      gaf_pkg::ST_CG_LO: begin
        ctrl.gsel      = gaf_pkg::GSEL_CORR;
        ctrl.mul.ld_lo = 1'b1;
      end
      gaf_pkg::ST_CG_HI: begin
        ctrl.gsel      = gaf_pkg::GSEL_CORR;
        ctrl.mul.ld_hi = 1'b1;
      end
      gaf_pkg::ST_CG_FIN: begin
        ctrl.gsel    = gaf_pkg::GSEL_CORR;
        ctrl.mul.fin = 1'b1;
      end
      // angle correction overlaps the start of the bias product
      gaf_pkg::ST_BG_LO: begin
        ctrl.gsel      = gaf_pkg::GSEL_BIAS;
        ctrl.mul.ld_lo = 1'b1;
        ctrl.alu_op    = gaf_pkg::ALU_CORR;
      end
      gaf_pkg::ST_BG_HI: begin
        ctrl.gsel      = gaf_pkg::GSEL_BIAS;
        ctrl.mul.ld_hi = 1'b1;
      end
      gaf_pkg::ST_BG_FIN: begin
        ctrl.gsel    = gaf_pkg::GSEL_BIAS;
        ctrl.mul.fin = 1'b1;
      end
      gaf_pkg::ST_BIAS:   ctrl.alu_op = gaf_pkg::ALU_BIAS;
      gaf_pkg::ST_OUT:    ctrl.out_load = !out_busy;
      default:            ctrl.in_ready = 1'b0;
    endcase
  end

`ifndef ASSERT_OFF
  a_mul_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.mul.ld_lo, ctrl.mul.ld_hi, ctrl.mul.fin}))
    else $error("multiplier controls overlap");
  a_lo_then_hi: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.mul.ld_lo |=> ctrl.mul.ld_hi)
    else $error("low half not followed by high half");
  a_hi_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.mul.ld_hi |=> ctrl.mul.fin)
    else $error("high half not followed by finish");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> !out_busy)
    else $error("output overwritten while held");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.in_ready && in_valid) |=> (ctrl.alu_op == gaf_pkg::ALU_RATE && !ctrl.axis))
    else $error("accepted item did not start on roll axis");
`endif

endmodule

// File: hw/rtl/gyro_accel_angle_fusion_unit.sv
// gyro_accel_angle_fusion_unit: two-axis angle and gyro bias tracker
// a new item is accepted only in the idle state, after the previous item has stepped both axes
// through 13 sequencer steps per axis and reached the output register, sharing one saturating adder
// and one 21x25 multiplier (two passes a product)
// a held result does not block acceptance of the next item
// reset (synchronous, active low) clears gains, angle estimates, biases and the output valid flag to zero
module gyro_accel_angle_fusion_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // roll_rate, pitch_rate, accel_pitch_ref, accel_roll_ref
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // roll_rate_fixed, pitch_rate_fixed, pitch_angle, roll_angle
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gaf_pkg::GAIN_W-1:0]    cfg_data
);

  localparam int IW = gaf_pkg::IN_W;
  localparam int SW = gaf_pkg::ST_W;
  localparam int OW = gaf_pkg::OP_W;
  localparam logic signed [OW-1:0] RND = (OW'(1) <<< FRAC_BITS) - OW'(1);

  gaf_pkg::ctrl_t ctrl;

  logic [gaf_pkg::GAIN_W-1:0] rate_gain_r [2];
  logic [gaf_pkg::GAIN_W-1:0] corr_gain_r [2];
  logic [gaf_pkg::GAIN_W-1:0] bias_gain_r [2];

  logic signed [IW-1:0] rate_r [2];
  logic signed [IW-1:0] ref_r  [2];
  logic signed [SW-1:0] est_r  [2];
  logic signed [SW-1:0] bias_r [2];
  logic signed [SW-1:0] crate_r [2];
  logic signed [SW-1:0] e_r;
  logic signed [SW-1:0] opnd_r;
  logic signed [SW-1:0] sc;

  logic                        ax;
  logic [gaf_pkg::GAIN_W-1:0]  gain;
  logic signed [OW-1:0]        a_op, b_op;
  logic                        alu_sub;
  logic signed [OW+1:0]        a_ext, b_ext, sum;
  logic signed [SW-1:0]        alu_res;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_busy;

  function automatic logic signed [OW-1:0] ext_st(input logic signed [SW-1:0] v);
    return $signed({v[SW-1], v});
  endfunction

  function automatic logic signed [OW-1:0] shift_in(input logic signed [IW-1:0] v);
    logic signed [OW-1:0] t;
    t = $signed({{(OW-IW){v[IW-1]}}, v});
    return t <<< FRAC_BITS;
  endfunction

  // truncate toward zero, then clamp to 16 bits
  function automatic logic [IW-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [OW-1:0] t;
    logic signed [OW-1:0] q;
    logic [IW-1:0]        r;
    t = ext_st(v) + (v[SW-1] ? RND : OW'(0));
    q = t >>> FRAC_BITS;
    if (q > OW'(32767)) begin
      r = 16'h7FFF;
    end else if (q < -OW'(32768)) begin
      r = 16'h8000;
    end else begin
      r = q[IW-1:0];
    end
    return r;
  endfunction

  assign ax        = ctrl.axis;
  assign in_tready = ctrl.in_ready && rst_n;
  assign cfg_ready = rst_n;
  assign out_busy  = out_valid_r && !out_tready;

  gaf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  always_comb begin
    case (ctrl.gsel)
      gaf_pkg::GSEL_RATE: gain = rate_gain_r[ax];
      gaf_pkg::GSEL_CORR: gain = corr_gain_r[ax];
      gaf_pkg::GSEL_BIAS: gain = bias_gain_r[ax];
      default:            gain = rate_gain_r[ax];
    endcase
  end

  gaf_mul u_mul (
    .clk  (clk),
    .ctrl (ctrl.mul),
    .x    (opnd_r),
    .g    (gain),
    .sc   (sc)
  );

  // shared saturating adder
  always_comb begin
    a_op    = '0;
    b_op    = '0;
    alu_sub = 1'b0;
    case (ctrl.alu_op)
      gaf_pkg::ALU_RATE: begin
        a_op    = shift_in(rate_r[ax]);
        b_op    = ext_st(bias_r[ax]);
        alu_sub = 1'b1;
      end
      gaf_pkg::ALU_EST: begin
        a_op = ext_st(est_r[ax]);
        b_op = ext_st(sc);
      end
      gaf_pkg::ALU_ERR: begin
        a_op    = ext_st(e_r);
        b_op    = shift_in(ref_r[ax]);
        alu_sub = 1'b1;
      end
      gaf_pkg::ALU_CORR: begin
        a_op    = ext_st(e_r);
        b_op    = ext_st(sc);
        alu_sub = 1'b1;
      end
      gaf_pkg::ALU_BIAS: begin
        a_op = ext_st(bias_r[ax]);
        b_op = ext_st(sc);
      end
      default: begin
        a_op = '0;
      end
    endcase
  end

  assign a_ext   = $signed({{2{a_op[OW-1]}}, a_op});
  assign b_ext   = $signed({{2{b_op[OW-1]}}, b_op});
  assign sum     = alu_sub ? (a_ext - b_ext) : (a_ext + b_ext);
  assign alu_res = gaf_pkg::sat_st($signed({{(gaf_pkg::SAT_IN_W-OW-2){sum[OW+1]}}, sum}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_gain_r[0] <= '0;
      rate_gain_r[1] <= '0;
      corr_gain_r[0] <= '0;
      corr_gain_r[1] <= '0;
      bias_gain_r[0] <= '0;
      bias_gain_r[1] <= '0;
    end else if (cfg_valid) begin
      case (gaf_pkg::cfg_reg_t'(cfg_index))
        gaf_pkg::CFG_ROLL_RATE_GAIN:     rate_gain_r[0] <= cfg_data;
        gaf_pkg::CFG_PITCH_RATE_GAIN:    rate_gain_r[1] <= cfg_data;
        gaf_pkg::CFG_ROLL_CORRECT_GAIN:  corr_gain_r[0] <= cfg_data;
        gaf_pkg::CFG_PITCH_CORRECT_GAIN: corr_gain_r[1] <= cfg_data;
        gaf_pkg::CFG_ROLL_BIAS_GAIN:     bias_gain_r[0] <= cfg_data;
        gaf_pkg::CFG_PITCH_BIAS_GAIN:    bias_gain_r[1] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // axis 0 is roll, axis 1 is pitch
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      rate_r[0] <= $signed(in_tdata[15:0]);
      rate_r[1] <= $signed(in_tdata[31:16]);
      ref_r[1]  <= $signed(in_tdata[47:32]);
      ref_r[0]  <= $signed(in_tdata[63:48]);
    end
    case (ctrl.alu_op)
      gaf_pkg::ALU_RATE: begin
        crate_r[ax] <= alu_res;
        opnd_r      <= alu_res;
      end
      gaf_pkg::ALU_EST: e_r    <= alu_res;
      gaf_pkg::ALU_ERR: opnd_r <= alu_res;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r[0]  <= '0;
      est_r[1]  <= '0;
      bias_r[0] <= '0;
      bias_r[1] <= '0;
    end else begin
      case (ctrl.alu_op)
        gaf_pkg::ALU_CORR: est_r[ax]  <= alu_res;
        gaf_pkg::ALU_BIAS: bias_r[ax] <= alu_res;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data_r <= {to_out(est_r[0]), to_out(est_r[1]),
                     to_out(crate_r[1]), to_out(crate_r[0])};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: bench/tb.sv
// tb: self-checking bench for gyro_accel_angle_fusion_unit, with a scoreboard class that
// predicts both fused angles and bias-corrected rates and checks them against every output item
// depends on gaf_pkg and gyro_accel_angle_fusion_unit
module tb;

  localparam int CFG_IDX_W     = gaf_pkg::CFG_IDX_W;
  localparam int GAIN_W        = gaf_pkg::GAIN_W;
  localparam int ST_W          = gaf_pkg::ST_W;
  localparam int GAIN_FRAC     = gaf_pkg::GAIN_FRAC;
  localparam int FRAC_BITS     = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 32;
  localparam int ITEMS_PER_SET = 50;
  localparam int SETS_PER_PASS = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef enum int {ROLE_RATE, ROLE_CORRECT, ROLE_BIAS} gain_role_t;

  class fusion_scoreboard;
    // index 0 is roll, index 1 is pitch
    logic [GAIN_W-1:0] rate_gain[2];
    logic [GAIN_W-1:0] correct_gain[2];
    logic [GAIN_W-1:0] bias_gain[2];
    longint            angle_est[2];
    longint            gyro_bias[2];
    logic [63:0]       expected_outputs[$];
    int                errors;

    function new();
      for (int ax = 0; ax < 2; ax++) begin
        rate_gain[ax]    = '0;
        correct_gain[ax] = '0;
        bias_gain[ax]    = '0;
        angle_est[ax]    = 0;
        gyro_bias[ax]    = 0;
      end
      errors = 0;
    endfunction

    static function longint clamp40(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (ST_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // floor(x * g / 2^16), saturated
    static function longint gain_mul(longint x, logic [GAIN_W-1:0] g);
      longint p;
      p = x * longint'(g);
      return clamp40(p >>> GAIN_FRAC);
    endfunction

    // truncate toward zero, then saturate to 16 bits
    static function logic [15:0] to_int16(longint v);
      longint i;
      if (v >= 0) begin
        i = v >>> FRAC_BITS;
      end else begin
        i = -((-v) >>> FRAC_BITS);
      end
      if (i > 32767) i = 32767;
      if (i < -32768) i = -32768;
      return i[15:0];
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      case (idx)
        gaf_pkg::CFG_ROLL_RATE_GAIN:     rate_gain[0]    = val;
        gaf_pkg::CFG_PITCH_RATE_GAIN:    rate_gain[1]    = val;
        gaf_pkg::CFG_ROLL_CORRECT_GAIN:  correct_gain[0] = val;
        gaf_pkg::CFG_PITCH_CORRECT_GAIN: correct_gain[1] = val;
        gaf_pkg::CFG_ROLL_BIAS_GAIN:     bias_gain[0]    = val;
        gaf_pkg::CFG_PITCH_BIAS_GAIN:    bias_gain[1]    = val;
        default: ;
      endcase
    endfunction

    function void note_input(logic [63:0] d);
      longint rate_in[2];
      longint accel_in[2];
      longint corrected[2];
      longint est;
      longint err;
      rate_in[0]  = $signed(d[15:0]);
      rate_in[1]  = $signed(d[31:16]);
      accel_in[1] = $signed(d[47:32]);
      accel_in[0] = $signed(d[63:48]);
      for (int ax = 0; ax < 2; ax++) begin
        corrected[ax] = clamp40(rate_in[ax] * (longint'(1) <<< FRAC_BITS) - gyro_bias[ax]);
        est = clamp40(angle_est[ax] + gain_mul(corrected[ax], rate_gain[ax]));
        err = clamp40(est - accel_in[ax] * (longint'(1) <<< FRAC_BITS));
        angle_est[ax] = clamp40(est - gain_mul(err, correct_gain[ax]));
        gyro_bias[ax] = clamp40(gyro_bias[ax] + gain_mul(err, bias_gain[ax]));
      end
      expected_outputs.push_back({to_int16(angle_est[0]), to_int16(angle_est[1]),
                                  to_int16(corrected[1]), to_int16(corrected[0])});
    endfunction

    function void check_result(logic [63:0] d);
      string       names[4];
      logic [63:0] want;
      names[0] = "roll_rate_fixed";
      names[1] = "pitch_rate_fixed";
      names[2] = "pitch_angle";
      names[3] = "roll_angle";
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected output item %h", $time, d);
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      for (int f = 0; f < 4; f++) begin
        if (want[16*f +: 16] !== d[16*f +: 16]) begin
          $display("%0t: %s expected %0d actual %0d", $time, names[f],
                   $signed(want[16*f +: 16]), $signed(d[16*f +: 16]));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // roll_rate, pitch_rate, accel_pitch_ref, accel_roll_ref
  logic [63:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // roll_rate_fixed, pitch_rate_fixed, pitch_angle, roll_angle
  logic [63:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;

  fusion_scoreboard sb;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               cycles;
  int               walk_roll;
  int               walk_pitch;

  gyro_accel_angle_fusion_unit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_gains(input logic [GAIN_W-1:0] rr, input logic [GAIN_W-1:0] pr,
                               input logic [GAIN_W-1:0] rc, input logic [GAIN_W-1:0] pc,
                               input logic [GAIN_W-1:0] rb, input logic [GAIN_W-1:0] pb);
    write_reg(gaf_pkg::CFG_ROLL_RATE_GAIN, rr);
    write_reg(gaf_pkg::CFG_PITCH_RATE_GAIN, pr);
    write_reg(gaf_pkg::CFG_ROLL_CORRECT_GAIN, rc);
    write_reg(gaf_pkg::CFG_PITCH_CORRECT_GAIN, pc);
    write_reg(gaf_pkg::CFG_ROLL_BIAS_GAIN, rb);
    write_reg(gaf_pkg::CFG_PITCH_BIAS_GAIN, pb);
    // spare indexes must leave every gain alone
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO,
                GAIN_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(input int rr, input int pr, input int pa, input int ra);
    int gap;
    logic [15:0] f_rr;
    logic [15:0] f_pr;
    logic [15:0] f_pa;
    logic [15:0] f_ra;
    f_rr = rr[15:0];
    f_pr = pr[15:0];
    f_pa = pa[15:0];
    f_ra = ra[15:0];
    in_tvalid <= 1'b1;
    in_tdata  <= {f_ra, f_pa, f_pr, f_rr};
    do @(posedge clk); while (!in_tready);
    sb.note_input({f_ra, f_pa, f_pr, f_rr});
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain(gain_role_t role);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k == 2) return GAIN_W'($urandom);
    case (role)
      ROLE_RATE:    return GAIN_W'($urandom_range(0, 'h2000));
      ROLE_CORRECT: return GAIN_W'($urandom_range(0, 'h10000));
      default:      return GAIN_W'($urandom_range(0, 'h0800));
    endcase
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  task automatic send_random_sample();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) begin
      // slowly moving attitude, gyro noise around a constant offset
      walk_roll  = walk_roll + $urandom_range(0, 80) - 40;
      walk_pitch = walk_pitch + $urandom_range(0, 80) - 40;
      if (walk_roll > 20000 || walk_roll < -20000) walk_roll = 0;
      if (walk_pitch > 20000 || walk_pitch < -20000) walk_pitch = 0;
      send_sample(300 + $urandom_range(0, 4000) - 2000, -150 + $urandom_range(0, 4000) - 2000,
                  walk_pitch + $urandom_range(0, 200) - 100,
                  walk_roll + $urandom_range(0, 200) - 100);
    end else if (k < 85) begin
      send_sample($urandom, $urandom, $urandom, $urandom);
    end else begin
      send_sample(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = gaf_pkg::CFG_ROLL_RATE_GAIN;
    cfg_data    = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    walk_roll   = 0;
    walk_pitch  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gains straight out of reset: rates pass through, angles stay at zero
    send_sample(0, 0, 0, 0);
    send_sample(32767, -32768, 32767, -32768);
    send_sample(-32768, 32767, -32768, 32767);
    send_sample(-1, 1, -1, 1);
    in_tvalid <= 1'b0;
    wait_drained();

    // full-scale gains drive the error, correction and bias terms into saturation
    program_gains('1, '1, '1, '1, '1, '1);
    write_reg(CFG_IDX_SPARE_LO, 24'hABCDEF);
    write_reg(CFG_IDX_SPARE_HI, 24'h123456);
    repeat (3) send_sample(32767, 32767, -32768, -32768);
    repeat (3) send_sample(-32768, -32768, 32767, 32767);
    in_tvalid <= 1'b0;
    wait_drained();

    // unity gains: estimate snaps to the accelerometer angle
    program_gains(24'h010000, 24'h010000, 24'h010000, 24'h010000, '0, '0);
    send_sample(1000, -1000, 1234, -4321);
    send_sample(-20000, 20000, -32768, 32767);
    send_sample(5, -5, 0, 0);
    in_tvalid <= 1'b0;
    wait_drained();

    // typical filter on roll, zero gains on pitch
    program_gains(24'h000100, '0, 24'h000800, '0, 24'h000040, '0);
    for (int i = 0; i < 8; i++) begin
      send_sample(100 * i - 300, 50 - 20 * i, 200 * i, -150 * i);
    end
    in_tvalid <= 1'b0;
    wait_drained();

    for (int pass = 0; pass < 3; pass++) begin
      tx_idle_pct = (pass == 0) ? 26 : (pass == 1) ? 74 : 0;
      rx_idle_pct = (pass == 0) ? 74 : (pass == 1) ? 26 : 0;
      for (int s = 0; s < SETS_PER_PASS; s++) begin
        program_gains(pick_gain(ROLE_RATE), pick_gain(ROLE_RATE),
                      pick_gain(ROLE_CORRECT), pick_gain(ROLE_CORRECT),
                      pick_gain(ROLE_BIAS), pick_gain(ROLE_BIAS));
        repeat (ITEMS_PER_SET) send_random_sample();
        in_tvalid <= 1'b0;
        wait_drained();
      end
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/gaf_pkg.sv
hw/rtl/gaf_mul.sv
hw/rtl/gaf_seq.sv
hw/rtl/gyro_accel_angle_fusion_unit.sv
bench/tb.sv
